// File: design/tep_pkg.sv
// tep_pkg: shared types and constants of the touch event to pointer block
// holds input kinds, event codes, register indexes, field widths, saturation bounds, fsm states and control structs
// no dependencies
package tep_pkg;

  // input event kinds
  localparam logic [2:0] KIND_X      = 3'd0;
  localparam logic [2:0] KIND_Y      = 3'd1;
  localparam logic [2:0] KIND_BUTTON = 3'd2;
  localparam logic [2:0] KIND_SYNC   = 3'd3;

  // pointer event codes
  localparam logic [1:0] EV_MOTION = 2'd0;
  localparam logic [1:0] EV_DOWN   = 2'd1;
  localparam logic [1:0] EV_UP     = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_X_MIN  = 3'd0;
  localparam logic [2:0] REG_X_MAX  = 3'd1;
  localparam logic [2:0] REG_Y_MIN  = 3'd2;
  localparam logic [2:0] REG_Y_MAX  = 3'd3;
  localparam logic [2:0] REG_WIDTH  = 3'd4;
  localparam logic [2:0] REG_HEIGHT = 3'd5;

  // field widths
  localparam int unsigned AXIS_W = 16;
  localparam int unsigned SIZE_W = 15;

  // saturation bounds of a 16 bit signed coordinate
  localparam logic [15:0] SAT_MAX = 16'h7FFF;
  localparam logic [15:0] SAT_MIN = 16'h8000;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_WRITE
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // capture axis operands from the accepted request
    logic div_step;   // one restoring divide step
    logic mul;        // ratio times screen size
    logic write;      // round, saturate and store the coordinate
    logic button_wr;  // store button level, mark change pending
    logic sync_wr;    // emit a pointer event
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic slot_free;  // output register empty or being taken
  } status_t;

endpackage

// File: design/touch_event_to_pointer.sv
// touch_event_to_pointer: an axis sample is taken with an operand load, then
// runs the one-bit-per-cycle restoring divider, a multiply state and a
// write-back state; button, sync and ignored requests are done in the cycle
// they are taken, and a sync result shows in the cycle after its request
// reset restores default axis limits and screen size and clears pointer state
// depends on tep_pkg, tep_ctrl, tep_datapath
module touch_event_to_pointer #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  // request channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         kind_i,
  input  logic signed [15:0] value_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         event_kind_o,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic               pressed_o
);

  tep_pkg::cmd_t    cmd;
  tep_pkg::status_t status;

  // config writes must arrive only while idle, the block does not enforce it; always taken
  assign cfg_ready_o = 1'b1;

  // controller
  tep_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath
  tep_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .kind_i       (kind_i),
    .value_i      (value_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .event_kind_o (event_kind_o),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o),
    .pressed_o    (pressed_o)
  );

endmodule

// File: design/tep_ctrl.sv
// tep_ctrl: controller fsm of the touch event to pointer block
// sequences operand load, divide steps, multiply and write-back, and issues button and sync writes
// depends on tep_pkg
module tep_ctrl #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [2:0]        kind_i,
  output logic              in_ready_o,
  input  tep_pkg::status_t  status_i,
  output tep_pkg::cmd_t     cmd_o
);

  localparam int unsigned QW = tep_pkg::AXIS_W + FRAC_BITS;
  localparam int unsigned CW = $clog2(QW);
  localparam logic [CW-1:0] LAST_STEP = CW'(QW - 1);

  tep_pkg::state_e state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            accept;
  logic            is_axis;

  // state and step counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tep_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign is_axis = (kind_i == tep_pkg::KIND_X) || (kind_i == tep_pkg::KIND_Y);
  assign accept  = in_valid_i && in_ready_o;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      tep_pkg::ST_IDLE: begin
        // a sync request needs room in the output register
        in_ready_o = (kind_i != tep_pkg::KIND_SYNC) || status_i.slot_free;
        if (accept) begin
          cmd_o.button_wr = (kind_i == tep_pkg::KIND_BUTTON);
          cmd_o.sync_wr   = (kind_i == tep_pkg::KIND_SYNC);
          if (is_axis) begin
            cmd_o.load = 1'b1;
            cnt_d      = '0;
            state_d    = tep_pkg::ST_DIV;
          end
        end
      end
      tep_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CW'(1);
        if (cnt_q == LAST_STEP) begin
          state_d = tep_pkg::ST_MUL;
        end
      end
      tep_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = tep_pkg::ST_WRITE;
      end
      tep_pkg::ST_WRITE: begin
        cmd_o.write = 1'b1;
        state_d     = tep_pkg::ST_IDLE;
      end
      default: begin
        state_d = tep_pkg::ST_IDLE;
      end
    endcase
  end

  // no request taken while a coordinate is in progress
  a_busy_no_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != tep_pkg::ST_IDLE) |-> !in_ready_o)
    else $error("request accepted while busy");

  // a load starts the divide at step zero
  a_load_starts_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == tep_pkg::ST_DIV) && (cnt_q == '0))
    else $error("load did not start divide");

  // last divide step hands over to the multiply
  a_div_to_mul : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tep_pkg::ST_DIV) && (cnt_q == LAST_STEP) |=> (state_q == tep_pkg::ST_MUL))
    else $error("divide did not end in multiply");

  // multiply is always followed by write-back
  a_mul_to_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tep_pkg::ST_MUL) |=> (state_q == tep_pkg::ST_WRITE))
    else $error("multiply not followed by write");

endmodule

// File: design/tep_datapath.sv
// tep_datapath: config registers, restoring divider, multiplier, pointer state
// and output register of the touch event to pointer block
// depends on tep_pkg
module tep_datapath #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration writes
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  // request payload
  input  logic [2:0]         kind_i,
  input  logic signed [15:0] value_i,
  // control
  input  tep_pkg::cmd_t      cmd_i,
  output tep_pkg::status_t   status_o,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         event_kind_o,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic               pressed_o
);

  localparam int unsigned AW = tep_pkg::AXIS_W;
  localparam int unsigned QW = AW + FRAC_BITS;
  localparam int unsigned PW = QW + tep_pkg::SIZE_W;
  localparam int unsigned TW = PW + 1 - FRAC_BITS;
  localparam logic [TW-1:0] POS_LIM = TW'(32767);
  localparam logic [TW-1:0] NEG_LIM = TW'(32768);

  // configuration registers
  logic signed [15:0] x_min_q, x_max_q, y_min_q, y_max_q;
  logic [14:0]        width_q, height_q;

  // pointer state
  logic signed [15:0] cur_x_q, cur_y_q;
  logic               button_q, changed_q;

  // arithmetic registers
  logic               axis_y_q, neg_q, zero_q;
  logic [AW-1:0]      dm_q, rem_q, rem_d;
  logic [QW-1:0]      quo_q, quo_d;
  logic [14:0]        size_q;
  logic [PW-1:0]      prod_q;

  // output register
  logic               out_valid_q;
  logic [1:0]         ev_q;
  logic signed [15:0] ox_q, oy_q;
  logic               op_q;

  // operand setup
  logic               sel_y;
  logic signed [15:0] lo, hi;
  logic signed [16:0] span, offs;
  logic [16:0]        span_mag, offs_mag;

  // divide step
  logic [AW:0]        trial, diff;
  logic               ge;

  // round and saturate
  logic [PW:0]        rounded;
  logic [TW-1:0]      mag;
  logic [15:0]        coord;

  // configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q  <= 16'sd0;
      x_max_q  <= 16'sd4095;
      y_min_q  <= 16'sd0;
      y_max_q  <= 16'sd4095;
      width_q  <= 15'd800;
      height_q <= 15'd480;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tep_pkg::REG_X_MIN:  x_min_q  <= cfg_data_i;
        tep_pkg::REG_X_MAX:  x_max_q  <= cfg_data_i;
        tep_pkg::REG_Y_MIN:  y_min_q  <= cfg_data_i;
        tep_pkg::REG_Y_MAX:  y_max_q  <= cfg_data_i;
        tep_pkg::REG_WIDTH:  width_q  <= cfg_data_i[14:0];
        tep_pkg::REG_HEIGHT: height_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // span and offset magnitudes for the selected axis
  assign sel_y    = (kind_i == tep_pkg::KIND_Y);
  assign lo       = sel_y ? y_min_q : x_min_q;
  assign hi       = sel_y ? y_max_q : x_max_q;
  assign span     = {hi[15], hi} - {lo[15], lo};
  assign offs     = {value_i[15], value_i} - {lo[15], lo};
  assign span_mag = span[16] ? 17'(-span) : span;
  assign offs_mag = offs[16] ? 17'(-offs) : offs;

  // one restoring divide step, quotient bits shift in from the right
  assign trial = {rem_q, quo_q[QW-1]};
  assign ge    = (trial >= {1'b0, dm_q});
  assign diff  = trial - {1'b0, dm_q};
  assign rem_d = ge ? diff[AW-1:0] : trial[AW-1:0];
  assign quo_d = {quo_q[QW-2:0], ge};

  // operand capture, divide iterations and multiply
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      axis_y_q <= sel_y;
      neg_q    <= offs[16] ^ span[16];
      zero_q   <= (span == 17'sd0);
      dm_q     <= span_mag[AW-1:0];
      size_q   <= sel_y ? height_q : width_q;
      rem_q    <= '0;
      quo_q    <= {offs_mag[AW-1:0], {FRAC_BITS{1'b0}}};
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
    if (cmd_i.mul) begin
      prod_q <= PW'(quo_q * size_q);
    end
  end

  // floor to integer pixels: negative values round their magnitude up
  assign rounded = {1'b0, prod_q} + {{(PW + 1 - FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
  assign mag     = neg_q ? rounded[PW:FRAC_BITS] : {1'b0, prod_q[PW-1:FRAC_BITS]};

  // saturate to 16 bit signed, zero span gives zero
  always_comb begin
    if (zero_q) begin
      coord = '0;
    end else if (!neg_q) begin
      coord = (mag > POS_LIM) ? tep_pkg::SAT_MAX : mag[15:0];
    end else begin
      coord = (mag > NEG_LIM) ? tep_pkg::SAT_MIN : 16'(~mag[15:0] + 16'd1);
    end
  end

  // pointer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      button_q  <= 1'b0;
      changed_q <= 1'b0;
    end else begin
      if (cmd_i.write) begin
        if (axis_y_q) begin
          cur_y_q <= coord;
        end else begin
          cur_x_q <= coord;
        end
      end
      if (cmd_i.button_wr) begin
        button_q  <= (value_i != 16'sd0);
        changed_q <= 1'b1;
      end else if (cmd_i.sync_wr) begin
        changed_q <= 1'b0;
      end
    end
  end

  // output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.sync_wr) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.sync_wr) begin
      ev_q <= changed_q ? (button_q ? tep_pkg::EV_DOWN : tep_pkg::EV_UP) : tep_pkg::EV_MOTION;
      ox_q <= cur_x_q;
      oy_q <= cur_y_q;
      op_q <= button_q;
    end
  end

  assign status_o.slot_free = !out_valid_q || out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign event_kind_o       = ev_q;
  assign pos_x_o            = ox_q;
  assign pos_y_o            = oy_q;
  assign pressed_o          = op_q;

endmodule

// File: dv/touch_event_to_pointer_tb.sv
// touch_event_to_pointer_tb: self-checking testbench of the touch event to pointer block
// predicts pointer events from its own copy of panel limits and pointer state
// depends on tep_pkg and touch_event_to_pointer
`timescale 1ns / 100ps

module touch_event_to_pointer_tb;

  localparam int unsigned FRAC = 16;
  // kinds outside the event set, and register indexes outside the map
  localparam logic [2:0] KIND_NOP      = 3'd4;
  localparam logic [2:0] KIND_RSVD_A   = 3'd5;
  localparam logic [2:0] KIND_RSVD_B   = 3'd6;
  localparam logic [2:0] KIND_TOP      = 3'd7;
  localparam logic [2:0] REG_SPARE_LO  = 3'd6;
  localparam logic [2:0] REG_SPARE_HI  = 3'd7;
  // long enough for an axis request to finish once its request is taken
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned DRAIN_LIMIT   = 4000;
  localparam int unsigned PHASE_ITEMS   = 160;

  typedef struct {
    logic signed [15:0] x_min;
    logic signed [15:0] x_max;
    logic signed [15:0] y_min;
    logic signed [15:0] y_max;
    logic [14:0]        width;
    logic [14:0]        height;
  } panel_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               level;
    logic               changed;
  } pointer_t;

  typedef struct {
    logic [1:0]         event_kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic               pressed;
  } pointer_event_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         kind = '0;
  logic signed [15:0] value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         event_kind;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic               pressed;

  panel_t         panel;
  pointer_t       pointer;
  pointer_event_t due_pointer_events[$];
  int unsigned    fail_count = 0;
  int unsigned    handled_requests = 0;
  int unsigned    checked_events = 0;
  int unsigned    panel_setups = 0;
  bit             back_to_back = 1'b0;

  touch_event_to_pointer #(
    .FRAC_BITS(FRAC)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .kind_i      (kind),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .event_kind_o(event_kind),
    .pos_x_o     (pos_x),
    .pos_y_o     (pos_y),
    .pressed_o   (pressed)
  );

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // run limit, far above the slowest correct run
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // raw reading to screen pixels: truncated ratio, floored product, saturated
  function automatic logic signed [15:0] scale_to_screen(logic signed [15:0] raw,
                                                         logic signed [15:0] lo,
                                                         logic signed [15:0] hi,
                                                         logic [14:0] size);
    longint span, offs, mag_n, mag_d, ratio, prod, pix;
    bit     neg;
    span = longint'(hi) - longint'(lo);
    if (span == 0) return '0;
    offs  = longint'(raw) - longint'(lo);
    neg   = (offs < 0) != (span < 0);
    mag_n = (offs < 0) ? -offs : offs;
    mag_d = (span < 0) ? -span : span;
    ratio = (mag_n << FRAC) / mag_d;
    if (neg) ratio = -ratio;
    prod = ratio * longint'(size);
    pix  = prod >>> FRAC;
    if (pix > 32767) pix = 32767;
    if (pix < -32768) pix = -32768;
    return pix[15:0];
  endfunction

  // panel limits after a register write
  function automatic void update_panel(logic [2:0] idx, logic [15:0] data);
    case (idx)
      tep_pkg::REG_X_MIN:  panel.x_min = data;
      tep_pkg::REG_X_MAX:  panel.x_max = data;
      tep_pkg::REG_Y_MIN:  panel.y_min = data;
      tep_pkg::REG_Y_MAX:  panel.y_max = data;
      tep_pkg::REG_WIDTH:  panel.width = data[14:0];
      tep_pkg::REG_HEIGHT: panel.height = data[14:0];
      default: ;
    endcase
  endfunction

  // pointer state after one request, queueing the event a sync emits
  function automatic void track_pointer(logic [2:0] k, logic signed [15:0] v);
    pointer_event_t ev;
    case (k)
      tep_pkg::KIND_X: pointer.x = scale_to_screen(v, panel.x_min, panel.x_max, panel.width);
      tep_pkg::KIND_Y: pointer.y = scale_to_screen(v, panel.y_min, panel.y_max, panel.height);
      tep_pkg::KIND_BUTTON: begin
        pointer.level   = (v != 0);
        pointer.changed = 1'b1;
      end
      tep_pkg::KIND_SYNC: begin
        if (pointer.changed) begin
          ev.event_kind   = pointer.level ? tep_pkg::EV_DOWN : tep_pkg::EV_UP;
          pointer.changed = 1'b0;
        end else begin
          ev.event_kind = tep_pkg::EV_MOTION;
        end
        ev.pos_x   = pointer.x;
        ev.pos_y   = pointer.y;
        ev.pressed = pointer.level;
        due_pointer_events.push_back(ev);
      end
      default: ;
    endcase
  endfunction

  // raw axis reading: mostly inside the span, sometimes its ends or anything
  function automatic logic signed [15:0] pick_raw(logic signed [15:0] lo,
                                                  logic signed [15:0] hi);
    int lower, upper;
    lower = (lo < hi) ? int'(lo) : int'(hi);
    upper = (lo < hi) ? int'(hi) : int'(lo);
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return 16'(lower + int'($urandom_range(upper - lower, 0)));
      6: return lo;
      7: return hi;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] pick_level();
    case ($urandom_range(3))
      0: return '0;
      1: return 16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  // sender gap: mostly short, a few long, none in back-to-back stretches
  task automatic sender_pause();
    int unsigned n, r;
    r = $urandom_range(99);
    if (back_to_back || r < 40) n = 0;
    else if (r < 90) n = $urandom_range(4, 1);
    else n = $urandom_range(50, 10);
    if (n > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // one request on the input channel, predicted once it is taken
  task automatic send_event(logic [2:0] k, logic signed [15:0] v);
    @(negedge clk);
    in_valid <= 1'b1;
    kind     <= k;
    value    <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_pointer(k, v);
    if (k < KIND_NOP) handled_requests++;
    sender_pause();
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    update_panel(idx, data);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // all events out and any axis request finished
  task automatic wait_idle();
    @(negedge clk) in_valid <= 1'b0;
    while (due_pointer_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic setup_panel(logic [15:0] xl, logic [15:0] xh, logic [15:0] yl,
                             logic [15:0] yh, logic [15:0] w, logic [15:0] h);
    wait_idle();
    write_reg(tep_pkg::REG_X_MIN, xl);
    write_reg(tep_pkg::REG_X_MAX, xh);
    write_reg(tep_pkg::REG_Y_MIN, yl);
    write_reg(tep_pkg::REG_Y_MAX, yh);
    write_reg(tep_pkg::REG_WIDTH, w);
    write_reg(tep_pkg::REG_HEIGHT, h);
    panel_setups++;
  endtask

  // receiver: ready runs, short stalls and a few long ones
  initial begin
    int unsigned seg_left, r;
    bit          seg_ready;
    seg_left  = 0;
    seg_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (seg_left == 0) begin
        r = $urandom_range(99);
        if (r < 50) begin
          seg_ready = 1'b1;
          seg_left  = $urandom_range(20, 1);
        end else if (r < 90) begin
          seg_ready = 1'b0;
          seg_left  = $urandom_range(3, 1);
        end else begin
          seg_ready = 1'b0;
          seg_left  = $urandom_range(40, 10);
        end
      end
      seg_left--;
      out_ready <= seg_ready;
    end
  end

  // check each pointer event against the oldest prediction
  always @(posedge clk) begin
    pointer_event_t ev;
    if (rst_n && out_valid && out_ready) begin
      if (due_pointer_events.size() == 0) begin
        $error("pointer event with none predicted: kind %0d x %0d y %0d pressed %0d",
               event_kind, pos_x, pos_y, pressed);
        fail_count++;
      end else begin
        ev = due_pointer_events.pop_front();
        checked_events++;
        if (event_kind !== ev.event_kind) begin
          $error("event_kind: expected %0d, got %0d", ev.event_kind, event_kind);
          fail_count++;
        end
        if (pos_x !== ev.pos_x) begin
          $error("pos_x: expected %0d, got %0d", ev.pos_x, pos_x);
          fail_count++;
        end
        if (pos_y !== ev.pos_y) begin
          $error("pos_y: expected %0d, got %0d", ev.pos_y, pos_y);
          fail_count++;
        end
        if (pressed !== ev.pressed) begin
          $error("pressed: expected %0d, got %0d", ev.pressed, pressed);
          fail_count++;
        end
      end
    end
  end

  // reset limits: axis extremes, every kind, button edges and ignored kinds
  task automatic test_directed_basics();
    send_event(tep_pkg::KIND_SYNC, 16'sd0);
    send_event(tep_pkg::KIND_X, 16'sd0);
    send_event(tep_pkg::KIND_Y, 16'sd4095);
    send_event(tep_pkg::KIND_SYNC, 16'sd0);
    send_event(tep_pkg::KIND_X, 16'sh7FFF);
    send_event(tep_pkg::KIND_Y, 16'sh8000);
    send_event(tep_pkg::KIND_SYNC, 16'sh7FFF);
    send_event(tep_pkg::KIND_BUTTON, 16'sd1);
    send_event(tep_pkg::KIND_SYNC, 16'sd0);
    send_event(tep_pkg::KIND_SYNC, 16'sd0);
    send_event(tep_pkg::KIND_BUTTON, 16'sd0);
    send_event(tep_pkg::KIND_SYNC, 16'sd0);
    // nonzero button values count as pressed, last write wins
    send_event(tep_pkg::KIND_BUTTON, 16'sh8000);
    send_event(tep_pkg::KIND_BUTTON, 16'sd0);
    send_event(tep_pkg::KIND_SYNC, 16'sd0);
    send_event(tep_pkg::KIND_BUTTON, 16'sd2);
    send_event(KIND_NOP, 16'sh7FFF);
    send_event(KIND_RSVD_A, 16'sh8000);
    send_event(KIND_RSVD_B, 16'sh5555);
    send_event(KIND_TOP, 16'shAAAA);
    send_event(tep_pkg::KIND_SYNC, 16'sd0);
  endtask

  // panel settings at the edges: zero span, inverted span, saturation, zero size
  task automatic test_panel_corners();
    // zero span on both axes
    setup_panel(16'd100, 16'd100, 16'hFFFB, 16'hFFFB, 16'd800, 16'd480);
    send_event(tep_pkg::KIND_X, 16'sh7FFF);
    send_event(tep_pkg::KIND_Y, 16'sh8000);
    send_event(tep_pkg::KIND_SYNC, 16'sd0);
    // inverted span, largest screen
    setup_panel(16'd4095, 16'd0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF);
    send_event(tep_pkg::KIND_X, 16'sd0);
    send_event(tep_pkg::KIND_Y, 16'sh7FFF);
    send_event(tep_pkg::KIND_SYNC, 16'sd0);
    send_event(tep_pkg::KIND_X, 16'sd4095);
    send_event(tep_pkg::KIND_Y, 16'sh8000);
    send_event(tep_pkg::KIND_SYNC, 16'sd0);
    send_event(tep_pkg::KIND_X, 16'sh8000);
    send_event(tep_pkg::KIND_SYNC, 16'sd0);
    // unit span saturates both ways
    setup_panel(16'd0, 16'd1, 16'd0, 16'hFFFF, 16'h7FFF, 16'h7FFF);
    send_event(tep_pkg::KIND_X, 16'sh7FFF);
    send_event(tep_pkg::KIND_Y, 16'sh7FFF);
    send_event(tep_pkg::KIND_SYNC, 16'sd0);
    send_event(tep_pkg::KIND_X, 16'sh8000);
    send_event(tep_pkg::KIND_Y, 16'sh8000);
    send_event(tep_pkg::KIND_SYNC, 16'sd0);
    // zero screen size, written with the unused top bit set
    setup_panel(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0000);
    send_event(tep_pkg::KIND_X, 16'sh7FFF);
    send_event(tep_pkg::KIND_Y, 16'sd1234);
    send_event(tep_pkg::KIND_SYNC, 16'sd0);
    // writes to unmapped indexes leave the panel alone
    wait_idle();
    write_reg(REG_SPARE_LO, 16'(($urandom)));
    write_reg(REG_SPARE_HI, 16'(($urandom)));
    write_reg(tep_pkg::REG_WIDTH, 16'd640);
    write_reg(REG_SPARE_HI, 16'hFFFF);
    send_event(tep_pkg::KIND_X, 16'sh4000);
    send_event(tep_pkg::KIND_SYNC, 16'sd0);
  endtask

  // random panels, mostly well-formed sample-then-sync sequences plus noise
  task automatic test_random_traffic();
    int unsigned phase_start, lim;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: setup_panel(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'd1);
        1: begin
          lim = $urandom_range(8, 1);
          setup_panel(16'd0, 16'(lim), 16'hFFF8, 16'(-lim), 16'h7FFF, 16'd3);
        end
        2: setup_panel(16'd200, 16'd3900, 16'd150, 16'd3950, 16'd1024, 16'd768);
        default: setup_panel(16'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      back_to_back = (ph == 3 || ph == 6);
      phase_start  = handled_requests;
      while (handled_requests - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(99) < 85) begin
          send_event(tep_pkg::KIND_X, pick_raw(panel.x_min, panel.x_max));
          if ($urandom_range(3) != 0)
            send_event(tep_pkg::KIND_Y, pick_raw(panel.y_min, panel.y_max));
          if ($urandom_range(2) == 0) send_event(tep_pkg::KIND_BUTTON, pick_level());
          if ($urandom_range(9) == 0) send_event(3'($urandom_range(KIND_TOP, KIND_NOP)),
                                                 16'($urandom));
          send_event(tep_pkg::KIND_SYNC, 16'($urandom));
        end else begin
          send_event(3'($urandom_range(KIND_TOP, 0)), 16'($urandom));
        end
      end
      back_to_back = 1'b0;
    end
  endtask

  // reset, tests in turn, drain and verdict
  initial begin
    int unsigned waited;
    panel.x_min  = 16'sd0;
    panel.x_max  = 16'sd4095;
    panel.y_min  = 16'sd0;
    panel.y_max  = 16'sd4095;
    panel.width  = 15'd800;
    panel.height = 15'd480;
    pointer      = '{x: '0, y: '0, level: 1'b0, changed: 1'b0};
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_directed_basics();
    test_panel_corners();
    test_random_traffic();

    @(negedge clk) in_valid <= 1'b0;
    waited = 0;
    while (due_pointer_events.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (due_pointer_events.size() != 0) begin
      $error("%0d predicted pointer events never arrived", due_pointer_events.size());
      fail_count++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d axis, button and sync requests under %0d panel setups",
             handled_requests, panel_setups);
    $display("compared %0d pointer events, %0d mismatches", checked_events, fail_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
